// ----- hw/rtl/pbnr_pkg.sv -----
// ----------------------------------------------------------------------------
// pbnr_pkg
// shared types and constants for the palette blend / nearest remap block
// ----------------------------------------------------------------------------
`default_nettype none

package pbnr_pkg;

    // default palette depth and register reset value
    localparam int unsigned PALETTE_SIZE_DEF = 256;
    localparam logic [15:0] LIMIT_AT_RESET   = 16'h0bb8;

    // blend arithmetic
    localparam logic [6:0]  FULL_PERCENT = 7'd100;
    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every x below 25600
    localparam logic [12:0] RECIP_100    = 13'd5243;
    localparam int unsigned RECIP_SHIFT  = 19;

    // request codes
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_BUILD = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // handshake between sequencer and blend unit
    typedef struct packed {
        logic start;
        logic done;
    } t_blend_ctl;

    // registered output of the distance unit
    typedef struct packed {
        logic        vld;
        logic        last;
        logic [15:0] distance;
    } t_dist_res;

endpackage

`default_nettype wire

// ----- hw/rtl/pbnr_palette_mem.sv -----
// ----------------------------------------------------------------------------
// pbnr_palette_mem
// palette store: one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module pbnr_palette_mem #(
    parameter int unsigned DEPTH = pbnr_pkg::PALETTE_SIZE_DEF,
    parameter int unsigned AW    = $clog2(DEPTH)
) (
    input  wire logic           i_clk,
    input  wire logic           i_we,
    input  wire logic [AW-1:0]  i_waddr,
    input  wire pbnr_pkg::t_rgb i_wdata,
    input  wire logic           i_re,
    input  wire logic [AW-1:0]  i_raddr,
    output pbnr_pkg::t_rgb      o_rdata
);

    pbnr_pkg::t_rgb r_mem [DEPTH];
    pbnr_pkg::t_rgb r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/pbnr_blend_unit.sv -----
// ----------------------------------------------------------------------------
// pbnr_blend_unit
// blends a source color toward a target, one channel at a time
// ----------------------------------------------------------------------------
`default_nettype none

module pbnr_blend_unit (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire pbnr_pkg::t_rgb i_src,
    input  wire pbnr_pkg::t_rgb i_tgt,
    input  wire logic [6:0]     i_pct,
    output logic                o_done,
    output pbnr_pkg::t_rgb      o_color
);

    logic           r_active;
    logic [1:0]     r_ch;
    logic           r_phase;      // 0: products, 1: divide and store
    logic           r_done;
    pbnr_pkg::t_rgb r_src;
    pbnr_pkg::t_rgb r_tgt;
    logic [6:0]     r_pct;
    logic [14:0]    r_pa;
    logic [14:0]    r_pb;
    pbnr_pkg::t_rgb r_color;

    logic [7:0]  src_ch;
    logic [7:0]  tgt_ch;
    logic [27:0] qa_full;
    logic [27:0] qb_full;
    logic [7:0]  qa;
    logic [7:0]  qb;
    logic [7:0]  blend_ch;

    always_comb begin
        unique case (r_ch)
            2'd0: begin
                src_ch = r_src.red;
                tgt_ch = r_tgt.red;
            end
            2'd1: begin
                src_ch = r_src.green;
                tgt_ch = r_tgt.green;
            end
            default: begin
                src_ch = r_src.blue;
                tgt_ch = r_tgt.blue;
            end
        endcase
    end

    // divide by 100 through reciprocal multiply
    assign qa_full  = 28'(r_pa) * 28'(pbnr_pkg::RECIP_100);
    assign qb_full  = 28'(r_pb) * 28'(pbnr_pkg::RECIP_100);
    assign qa       = 8'(qa_full >> pbnr_pkg::RECIP_SHIFT);
    assign qb       = 8'(qb_full >> pbnr_pkg::RECIP_SHIFT);
    assign blend_ch = qa + qb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_ch     <= 2'd0;
            r_phase  <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_active <= 1'b1;
                r_ch     <= 2'd0;
                r_phase  <= 1'b0;
            end else if (r_active) begin
                r_phase <= ~r_phase;
                if (r_phase) begin
                    if (r_ch == 2'd2) begin
                        r_active <= 1'b0;
                        r_done   <= 1'b1;
                    end else begin
                        r_ch <= r_ch + 2'd1;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_src <= i_src;
            r_tgt <= i_tgt;
            r_pct <= i_pct;
        end
        if (r_active && !r_phase) begin
            r_pa <= 15'(src_ch) * 15'(pbnr_pkg::FULL_PERCENT - r_pct);
            r_pb <= 15'(tgt_ch) * 15'(r_pct);
        end
        if (r_active && r_phase) begin
            unique case (r_ch)
                2'd0:    r_color.red   <= blend_ch;
                2'd1:    r_color.green <= blend_ch;
                default: r_color.blue  <= blend_ch;
            endcase
        end
    end

    assign o_done  = r_done;
    assign o_color = r_color;

endmodule

`default_nettype wire

// ----- hw/rtl/pbnr_dist_unit.sv -----
// ----------------------------------------------------------------------------
// pbnr_dist_unit
// squared rgb distance of one palette entry, 16-bit wrap, registered
// ----------------------------------------------------------------------------
`default_nettype none

module pbnr_dist_unit #(
    parameter int unsigned AW = 8
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_vld,
    input  wire logic           i_last,
    input  wire logic [AW-1:0]  i_idx,
    input  wire pbnr_pkg::t_rgb i_entry,
    input  wire pbnr_pkg::t_rgb i_color,
    output pbnr_pkg::t_dist_res o_res,
    output logic [AW-1:0]       o_idx
);

    logic [7:0]  dr;
    logic [7:0]  dg;
    logic [7:0]  db;
    logic [15:0] sum;

    logic        r_vld;
    logic        r_last;
    logic [15:0] r_dist;
    logic [AW-1:0] r_idx;

    assign dr = (i_color.red >= i_entry.red) ? i_color.red - i_entry.red
                                             : i_entry.red - i_color.red;
    assign dg = (i_color.green >= i_entry.green) ? i_color.green - i_entry.green
                                                 : i_entry.green - i_color.green;
    assign db = (i_color.blue >= i_entry.blue) ? i_color.blue - i_entry.blue
                                               : i_entry.blue - i_color.blue;

    // sum wraps at 16 bits
    assign sum = 16'(16'(dr) * 16'(dr)) + 16'(16'(dg) * 16'(dg))
               + 16'(16'(db) * 16'(db));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= 1'b0;
            r_last <= 1'b0;
        end else begin
            r_vld  <= i_vld;
            r_last <= i_vld && i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist <= sum;
        r_idx  <= i_idx;
    end

    assign o_res.vld      = r_vld;
    assign o_res.last     = r_last;
    assign o_res.distance = r_dist;
    assign o_idx          = r_idx;

endmodule

`default_nettype wire

// ----- hw/rtl/palette_blend_nearest_remap.sv -----
// ----------------------------------------------------------------------------
// palette_blend_nearest_remap
// palette store with blend-and-nearest-entry remap search
// ----------------------------------------------------------------------------
// load item: written at the accept edge, busy stays low, no result
// build item: busy from acceptance until the done state ends, strobe in the done state
// steps: source read, blend start, blend of the three channels, a scan with one palette read a cycle
// into the one distance unit, the read and distance registers draining, then the result
// synchronous active-low reset: idle, distance_limit 3000, palette undefined until loaded
// results cannot be stalled
`default_nettype none

module palette_blend_nearest_remap #(
    parameter int unsigned PALETTE_SIZE = pbnr_pkg::PALETTE_SIZE_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // command channel
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_entry_index,
    input  wire logic [7:0]  i_red,
    input  wire logic [7:0]  i_green,
    input  wire logic [7:0]  i_blue,
    input  wire logic [6:0]  i_blend_percent,
    // result channel
    output logic             o_strobe,
    output logic [7:0]       o_source_index,
    output logic [7:0]       o_remap_index,
    output logic             o_found,
    // configuration
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata
);

    localparam int unsigned AW = $clog2(PALETTE_SIZE);
    localparam logic [AW-1:0] LAST_IDX = AW'(PALETTE_SIZE - 1);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SRC      = 7'b0000010,
        S_BLEND_GO = 7'b0000100,
        S_BLEND    = 7'b0001000,
        S_SCAN     = 7'b0010000,
        S_DRAIN    = 7'b0100000,
        S_DONE     = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    // captured build item
    logic [7:0]     r_idx;
    logic           r_src_oob;
    pbnr_pkg::t_rgb r_tgt;
    logic [6:0]     r_pct;

    logic [15:0]    r_limit;

    // scan address and read-stage tags
    logic [AW-1:0]  r_k;
    logic           r_p1_vld;
    logic           r_p1_last;
    logic [AW-1:0]  r_p1_idx;

    // running best
    logic [15:0]    r_best;
    logic [AW-1:0]  r_best_idx;
    logic           r_hit;

    logic           accept;
    logic           load_ok;
    pbnr_pkg::t_rgb in_color;
    pbnr_pkg::t_rgb rd_data;
    pbnr_pkg::t_rgb src_color;
    pbnr_pkg::t_rgb blend_color;
    pbnr_pkg::t_blend_ctl blend_ctl;
    pbnr_pkg::t_dist_res  dist_res;
    logic [AW-1:0]  dist_idx;
    logic           mem_re;
    logic [AW-1:0]  mem_raddr;

    assign busy     = (r_state != S_IDLE);
    assign accept   = start && !busy;
    assign in_color = '{red: i_red, green: i_green, blue: i_blue};

    // loads go straight into the store; out-of-range ones are dropped
    assign load_ok  = accept && (i_req_type == pbnr_pkg::REQ_LOAD)
                   && (32'(i_entry_index) < PALETTE_SIZE);

    // read port: source entry once, then every entry in index order
    assign mem_re    = (r_state == S_SRC) || (r_state == S_SCAN);
    assign mem_raddr = (r_state == S_SRC) ? AW'(r_idx) : r_k;

    pbnr_palette_mem #(
        .DEPTH (PALETTE_SIZE),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (load_ok),
        .i_waddr (AW'(i_entry_index)),
        .i_wdata (in_color),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd_data)
    );

    // a source beyond the palette blends from black
    assign src_color       = r_src_oob ? '0 : rd_data;
    assign blend_ctl.start = (r_state == S_BLEND_GO);

    pbnr_blend_unit u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (blend_ctl.start),
        .i_src   (src_color),
        .i_tgt   (r_tgt),
        .i_pct   (r_pct),
        .o_done  (blend_ctl.done),
        .o_color (blend_color)
    );

    pbnr_dist_unit #(
        .AW (AW)
    ) u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (r_p1_vld),
        .i_last  (r_p1_last),
        .i_idx   (r_p1_idx),
        .i_entry (rd_data),
        .i_color (blend_color),
        .o_res   (dist_res),
        .o_idx   (dist_idx)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept && (i_req_type == pbnr_pkg::REQ_BUILD)) begin
                    n_state = S_SRC;
                end
            end
            S_SRC:      n_state = S_BLEND_GO;
            S_BLEND_GO: n_state = S_BLEND;
            S_BLEND: begin
                if (blend_ctl.done) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_k == LAST_IDX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (dist_res.vld && dist_res.last) begin
                    n_state = S_DONE;
                end
            end
            S_DONE:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_limit  <= pbnr_pkg::LIMIT_AT_RESET;
            r_p1_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_p1_vld <= (r_state == S_SCAN);
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_idx     <= i_entry_index;
            r_src_oob <= !(32'(i_entry_index) < PALETTE_SIZE);
            r_tgt     <= in_color;
            // percent above full saturates
            r_pct     <= (i_blend_percent > pbnr_pkg::FULL_PERCENT)
                       ? pbnr_pkg::FULL_PERCENT : i_blend_percent;
        end

        if (r_state == S_BLEND) begin
            r_k <= '0;
        end else if (r_state == S_SCAN) begin
            r_k <= r_k + AW'(1);
        end

        r_p1_idx  <= r_k;
        r_p1_last <= (r_k == LAST_IDX);

        // start from the limit so only entries at or under it count;
        // <= lets a later entry win a tie
        if (r_state == S_BLEND_GO) begin
            r_best     <= r_limit;
            r_best_idx <= '0;
            r_hit      <= 1'b0;
        end else if (dist_res.vld && (dist_res.distance <= r_best)) begin
            r_best     <= dist_res.distance;
            r_best_idx <= dist_idx;
            r_hit      <= 1'b1;
        end
    end

    // result: one cycle in the done state
    assign o_strobe       = (r_state == S_DONE);
    assign o_source_index = r_idx;
    assign o_remap_index  = r_hit ? 8'(r_best_idx) : 8'd0;
    assign o_found        = r_hit;

    // result strobe is a single cycle
    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    // an accepted build item makes the block busy
    a_build_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == pbnr_pkg::REQ_BUILD)) |=> busy)
        else $error("build item accepted but block not busy");

    // a load item never produces a result
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && (i_req_type == pbnr_pkg::REQ_LOAD)) |=> !o_strobe)
        else $error("result after load item");

    // distances only come out while scanning or draining
    a_dist_in_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dist_res.vld |-> ((r_state == S_SCAN) || (r_state == S_DRAIN)))
        else $error("distance outside scan");

    // the result follows the last distance of the scan
    a_done_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(dist_res.vld && dist_res.last))
        else $error("result without completed scan");

endmodule

`default_nettype wire

// ----- tb/palette_blend_nearest_remap_tb.sv -----
// ----------------------------------------------------------------------------
// palette_blend_nearest_remap_tb
// self-checking regression for the palette blend / nearest remap block: the
// palette is filled first, then directed blend and search cases run, then
// random load/build traffic under several distance limits and sender idle
// rates; each remap result is checked against an in-bench prediction of the
// blended color and its nearest palette entry
// ----------------------------------------------------------------------------
module palette_blend_nearest_remap_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned PAL_DEPTH     = pbnr_pkg::PALETTE_SIZE_DEF;
    // busy span of one build, used for the settle pause at the end
    localparam int unsigned SCAN_CYCLES   = PAL_DEPTH + 12;
    // watchdog limit, set well above the slowest correct run
    localparam int unsigned CYCLE_LIMIT   = 3_000_000;
    localparam int unsigned SEGMENT_ITEMS = 220;
    localparam int unsigned MAX_PRINTS    = 40;

    // one command item as driven on the ports
    typedef struct packed {
        logic           req;
        logic [7:0]     idx;
        pbnr_pkg::t_rgb color;
        logic [6:0]     pct;
    } t_remap_cmd;

    // one result item as seen on the result ports
    typedef struct packed {
        logic [7:0] src;
        logic [7:0] remap;
        logic       found;
    } t_remap_res;

    // every input known from time zero, reset held low from the start
    logic        i_clk           = 1'b0;
    logic        i_rst_n         = 1'b0;
    logic        start           = 1'b0;
    logic        busy;
    logic        i_req_type      = pbnr_pkg::REQ_LOAD;
    logic [7:0]  i_entry_index   = 8'd0;
    logic [7:0]  i_red           = 8'd0;
    logic [7:0]  i_green         = 8'd0;
    logic [7:0]  i_blue          = 8'd0;
    logic [6:0]  i_blend_percent = 7'd0;
    logic        o_strobe;
    logic [7:0]  o_source_index;
    logic [7:0]  o_remap_index;
    logic        o_found;
    logic        i_cfg_we        = 1'b0;
    logic [15:0] i_cfg_wdata     = 16'd0;

    // shadow of the block state
    pbnr_pkg::t_rgb pal_shadow [PAL_DEPTH];
    logic [15:0]    limit_shadow = pbnr_pkg::LIMIT_AT_RESET;

    t_remap_res  remap_expect_q [$];
    int unsigned error_count   = 0;
    int unsigned cycle_count   = 0;
    int unsigned send_idle_pct = 0;

    palette_blend_nearest_remap #(
        .PALETTE_SIZE(PAL_DEPTH)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_entry_index  (i_entry_index),
        .i_red          (i_red),
        .i_green        (i_green),
        .i_blue         (i_blue),
        .i_blend_percent(i_blend_percent),
        .o_strobe       (o_strobe),
        .o_source_index (o_source_index),
        .o_remap_index  (o_remap_index),
        .o_found        (o_found),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("palette_blend_nearest_remap regression: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------

    // one channel moved p percent toward the target, each quotient truncated
    function automatic logic [7:0] blend_chan(input logic [7:0] s, input logic [7:0] t,
                                              input int unsigned p);
        return 8'((32'(s) * (pbnr_pkg::FULL_PERCENT - p)) / pbnr_pkg::FULL_PERCENT
                  + (p * 32'(t)) / pbnr_pkg::FULL_PERCENT);
    endfunction

    // squared rgb distance, summed in 16 bits with wraparound
    function automatic logic [15:0] sq_dist(input pbnr_pkg::t_rgb a, input pbnr_pkg::t_rgb b);
        int unsigned dr;
        int unsigned dg;
        int unsigned db;
        dr = (a.red   >= b.red)   ? a.red   - b.red   : b.red   - a.red;
        dg = (a.green >= b.green) ? a.green - b.green : b.green - a.green;
        db = (a.blue  >= b.blue)  ? a.blue  - b.blue  : b.blue  - a.blue;
        return 16'(dr * dr + dg * dg + db * db);
    endfunction

    // update the shadow palette, or work out the remap result of a build
    function automatic void remap_predict(input t_remap_cmd c);
        pbnr_pkg::t_rgb src;
        pbnr_pkg::t_rgb mix;
        int unsigned    pct;
        logic [15:0]    d;
        logic [15:0]    best;
        int unsigned    best_k;
        logic           hit;
        t_remap_res     r;
        if (c.req == pbnr_pkg::REQ_LOAD) begin
            pal_shadow[c.idx] = c.color;
            return;
        end
        // percent above full saturates
        pct = (c.pct > pbnr_pkg::FULL_PERCENT) ? pbnr_pkg::FULL_PERCENT : c.pct;
        src = pal_shadow[c.idx];
        mix.red   = blend_chan(src.red,   c.color.red,   pct);
        mix.green = blend_chan(src.green, c.color.green, pct);
        mix.blue  = blend_chan(src.blue,  c.color.blue,  pct);
        // full scan, later entry wins a tie, only within the limit
        best   = limit_shadow;
        best_k = 0;
        hit    = 1'b0;
        for (int unsigned k = 0; k < PAL_DEPTH; k++) begin
            d = sq_dist(mix, pal_shadow[k]);
            if (d <= best) begin
                best   = d;
                best_k = k;
                hit    = 1'b1;
            end
        end
        r.src   = c.idx;
        r.remap = hit ? 8'(best_k) : 8'd0;
        r.found = hit;
        remap_expect_q.push_back(r);
    endfunction

    // ------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (error_count < MAX_PRINTS)
            $display("%0t ns: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
        error_count++;
    endtask

    // results cannot be stalled, so every strobe is taken at its rising edge
    always @(posedge i_clk) begin
        t_remap_res want;
        if (i_rst_n && o_strobe) begin
            if (remap_expect_q.size() == 0) begin
                report_mismatch("unexpected result, source_index", o_source_index, 0);
            end else begin
                want = remap_expect_q.pop_front();
                if (o_source_index !== want.src)
                    report_mismatch("source_index", o_source_index, want.src);
                if (o_remap_index !== want.remap)
                    report_mismatch("remap_index", o_remap_index, want.remap);
                if (o_found !== want.found)
                    report_mismatch("found", o_found, want.found);
            end
        end
    end

    // ------------------------------------------------------------------
    // driving
    // ------------------------------------------------------------------

    function automatic t_remap_cmd mk_cmd(input logic req, input logic [7:0] idx,
                                          input logic [7:0] r, input logic [7:0] g,
                                          input logic [7:0] b, input logic [6:0] pct);
        t_remap_cmd c;
        c.req   = req;
        c.idx   = idx;
        c.color = '{red: r, green: g, blue: b};
        c.pct   = pct;
        return c;
    endfunction

    // one item: optional idle gap, then hold start until accepted
    task automatic send_item(input t_remap_cmd c);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            start = 1'b0;
            @(negedge i_clk);
        end
        start           = 1'b1;
        i_req_type      = c.req;
        i_entry_index   = c.idx;
        i_red           = c.color.red;
        i_green         = c.color.green;
        i_blue          = c.color.blue;
        i_blend_percent = c.pct;
        do @(posedge i_clk); while (busy);
        remap_predict(c);
    endtask

    // drop start, wait for every outstanding result and for busy to clear
    task automatic wait_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (remap_expect_q.size() != 0) @(posedge i_clk);
        // a load just accepted has no result to wait for, give it a moment
        repeat (4) @(posedge i_clk);
        while (busy) @(posedge i_clk);
    endtask

    // limit is only written while the block sits idle
    task automatic set_limit(input logic [15:0] v);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = v;
        @(negedge i_clk);
        i_cfg_we     = 1'b0;
        limit_shadow = v;
    endtask

    function automatic t_remap_cmd random_cmd();
        t_remap_cmd c;
        c.req   = ($urandom_range(99) < 45) ? pbnr_pkg::REQ_BUILD : pbnr_pkg::REQ_LOAD;
        c.idx   = 8'($urandom_range(255));
        c.color = pbnr_pkg::t_rgb'(24'($urandom_range(24'hFF_FFFF)));
        c.pct   = 7'($urandom_range(127));
        if ($urandom_range(2) == 0) begin
            // reuse a palette color: duplicate loads make ties, and strong
            // blends toward it land on or close to an existing entry
            c.color = pal_shadow[$urandom_range(PAL_DEPTH - 1)];
            if (c.req == pbnr_pkg::REQ_BUILD && $urandom_range(1) == 1)
                c.pct = 7'($urandom_range(127, 95));
        end
        return c;
    endfunction

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // every entry written before any build, since a build scans them all
    task automatic test_palette_fill();
        pbnr_pkg::t_rgb c;
        for (int unsigned k = 0; k < PAL_DEPTH; k++) begin
            c = pbnr_pkg::t_rgb'(24'($urandom_range(24'hFF_FFFF)));
            if (k == 0)               c = 24'h00_0000;  // black
            if (k == PAL_DEPTH - 1)   c = 24'hFF_FFFF;  // white
            if (k == 10 || k == 200)  c = 24'h40_80C0;  // duplicate pair for ties
            send_item(mk_cmd(pbnr_pkg::REQ_LOAD, 8'(k), c.red, c.green, c.blue, 7'd0));
        end
    endtask

    // blend extremes under the reset limit
    task automatic test_blend_cases();
        send_item(mk_cmd(pbnr_pkg::REQ_BUILD, 8'd0,   8'hFF, 8'hFF, 8'hFF, 7'd0)); // source kept
        send_item(mk_cmd(pbnr_pkg::REQ_BUILD, 8'd255, 8'h00, 8'h00, 8'h00, 7'd0));
        send_item(mk_cmd(pbnr_pkg::REQ_BUILD, 8'd0,   8'hFF, 8'hFF, 8'hFF, 7'd100)); // full
        send_item(mk_cmd(pbnr_pkg::REQ_BUILD, 8'd0,   8'hFF, 8'hFF, 8'hFF, 7'd127)); // saturates
        send_item(mk_cmd(pbnr_pkg::REQ_BUILD, 8'd0,   8'hFF, 8'hFF, 8'hFF, 7'd50)); // truncation
        send_item(mk_cmd(pbnr_pkg::REQ_BUILD, 8'd10,  8'h00, 8'h00, 8'h00, 7'd0)); // tie
        send_item(mk_cmd(pbnr_pkg::REQ_BUILD, 8'd255, 8'h00, 8'h00, 8'h00, 7'd1));
        send_item(mk_cmd(pbnr_pkg::REQ_BUILD, 8'd128, 8'h40, 8'h80, 8'hC0, 7'd100));
        send_item(mk_cmd(pbnr_pkg::REQ_BUILD, 8'd200, 8'hFF, 8'h00, 8'hFF, 7'd101));
    endtask

    // limit edges, wrapped distance and a load read back by a build
    task automatic test_limit_edges();
        set_limit(16'd0);
        // exact tie only
        send_item(mk_cmd(pbnr_pkg::REQ_BUILD, 8'd10, 8'h00, 8'h00, 8'h00, 7'd0));
        // most likely none
        send_item(mk_cmd(pbnr_pkg::REQ_BUILD, 8'd0,  8'h01, 8'h02, 8'h03, 7'd100));
        set_limit(16'hFFFF);
        // always a match
        send_item(mk_cmd(pbnr_pkg::REQ_BUILD, 8'd77, 8'h12, 8'h34, 8'h56, 7'd64));
        // 3 * 148^2 wraps to 176, so a far entry looks close
        send_item(mk_cmd(pbnr_pkg::REQ_LOAD,  8'd77, 8'd200, 8'd200, 8'd200, 7'd0));
        set_limit(16'd200);
        send_item(mk_cmd(pbnr_pkg::REQ_BUILD, 8'd0,  8'd52, 8'd52, 8'd52, 7'd100));
        send_item(mk_cmd(pbnr_pkg::REQ_LOAD,  8'd3,  8'd9, 8'd9, 8'd9, 7'd0));
        send_item(mk_cmd(pbnr_pkg::REQ_BUILD, 8'd3,  8'hFF, 8'hFF, 8'hFF, 7'd0));
    endtask

    // random traffic in three segments, each under its own limit
    task automatic test_random_phase(input int unsigned idle_pct, input logic [15:0] edge_limit);
        logic [15:0] lims [3];
        lims[0] = edge_limit;
        lims[1] = 16'($urandom_range(1500));
        lims[2] = 16'($urandom_range(16'hFFFF));
        send_idle_pct = idle_pct;
        for (int s = 0; s < 3; s++) begin
            set_limit(lims[s]);
            for (int unsigned i = 0; i < SEGMENT_ITEMS; i++) begin
                // now and then hold off until everything has come back
                if ($urandom_range(199) == 0) wait_drained();
                send_item(random_cmd());
            end
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_idle_pct = 7;
        test_palette_fill();
        test_blend_cases();
        test_limit_edges();

        test_random_phase(7,  16'd0);
        test_random_phase(82, 16'hFFFF);
        test_random_phase(0,  pbnr_pkg::LIMIT_AT_RESET);

        // nothing outstanding, then a quiet spell to catch stray strobes
        wait_drained();
        repeat (SCAN_CYCLES + 16) @(posedge i_clk);
        if (error_count == 0) begin
            $display("palette_blend_nearest_remap regression: pass");
        end else begin
            $display("palette_blend_nearest_remap regression: fail");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/pbnr_pkg.sv
hw/rtl/pbnr_palette_mem.sv
hw/rtl/pbnr_blend_unit.sv
hw/rtl/pbnr_dist_unit.sv
hw/rtl/palette_blend_nearest_remap.sv
tb/palette_blend_nearest_remap_tb.sv
